// ===== rtl/dbq_pkg.sv =====
package dbq_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + 4;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  // Register indexes on the configuration port
  localparam cfg_idx_t CFG_B0  = 3'd0;
  localparam cfg_idx_t CFG_B1  = 3'd1;
  localparam cfg_idx_t CFG_B2  = 3'd2;
  localparam cfg_idx_t CFG_A1  = 3'd3;
  localparam cfg_idx_t CFG_A2  = 3'd4;
  localparam cfg_idx_t CFG_DEC = 3'd5;

  // Notch defaults, Q2.16
  localparam coef_t B0_RST = 18'sd60255;
  localparam coef_t B1_RST = -18'sd119731;
  localparam coef_t B2_RST = 18'sd60255;
  localparam coef_t A1_RST = -18'sd119731;
  localparam coef_t A2_RST = 18'sd54973;
  localparam logic  DEC_RST = 1'b1;

  localparam logic [1:0] PASS_CNT = 2'd2;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
    logic  decimate_enable;
  } cfg_t;

  typedef struct packed {
    sample_t x;
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } taps_t;

endpackage

// ===== rtl/decimating_biquad_filter_unit.sv =====
// Channel  Dir  Handshake          Payload
// in       in   in_valid/in_stall  in_sample[15:0] s, in_record_start
// out      out  out_valid/out_stall out_filtered[15:0] s
// cfg      in   cfg_valid/cfg_ready cfg_index[2:0], cfg_data[17:0]
//
// One item per cycle sustained while out is not stalled; a kept item passes the input
// register and then the result register before out_valid rises. The loop through the
// previous outputs (multiply, sum, round) is combinational from the input and history registers.
// Synchronous active-low reset loads notch coefficients and clears history.
// Dropped (odd) items retire even while out is stalled; kept items wait
// for the result register to free up. cfg_ready is always high.
module decimating_biquad_filter_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [15:0]       in_sample,
  input  logic                     in_record_start,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [15:0]       out_filtered,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [17:0]              cfg_data
);

  dbq_pkg::cfg_t    cfg;
  dbq_pkg::taps_t   taps;
  dbq_pkg::sample_t mac_y;

  // input register
  logic             s1_valid_r, s1_valid_nxt;
  dbq_pkg::sample_t s1_sample_r;
  logic             s1_start_r;

  // history
  dbq_pkg::sample_t x1_r, x2_r, y1_r, y2_r;
  logic [1:0]       kept_r;
  logic             odd_r;

  // result register
  logic             out_valid_r, out_valid_nxt;
  dbq_pkg::sample_t out_filtered_r;

  dbq_pkg::sample_t x1_eff, x2_eff, y1_eff, y2_eff, y_sel;
  logic [1:0]       kept_eff;
  logic             odd_eff;
  logic             drop;
  logic             out_free;
  logic             s1_fire;
  logic             s1_emit;
  logic             in_fire;

  assign cfg_ready = 1'b1;

  dbq_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // record start clears history ahead of the item itself
  assign x1_eff   = s1_start_r ? '0 : x1_r;
  assign x2_eff   = s1_start_r ? '0 : x2_r;
  assign y1_eff   = s1_start_r ? '0 : y1_r;
  assign y2_eff   = s1_start_r ? '0 : y2_r;
  assign kept_eff = s1_start_r ? 2'd0 : kept_r;
  assign odd_eff  = s1_start_r ? 1'b0 : odd_r;

  assign drop     = cfg.decimate_enable && odd_eff;
  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && (drop || out_free);
  assign s1_emit  = s1_fire && !drop;
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_fire  = in_valid && !in_stall;

  assign taps = {s1_sample_r, x1_eff, x2_eff, y1_eff, y2_eff};

  dbq_mac u_mac (
    .cfg  (cfg),
    .taps (taps),
    .y    (mac_y)
  );

  assign y_sel = (kept_eff < dbq_pkg::PASS_CNT) ? s1_sample_r : mac_y;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      kept_r      <= 2'd0;
      odd_r       <= 1'b0;
      x1_r        <= '0;
      x2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        odd_r <= !odd_eff;
        if (drop) begin
          // odd item: only the phase moves, a record start still clears
          kept_r <= kept_eff;
          x1_r   <= x1_eff;
          x2_r   <= x2_eff;
          y1_r   <= y1_eff;
          y2_r   <= y2_eff;
        end else begin
          kept_r <= (kept_eff < dbq_pkg::PASS_CNT) ? kept_eff + 2'd1 : kept_eff;
          x1_r   <= s1_sample_r;
          x2_r   <= x1_eff;
          y1_r   <= y_sel;
          y2_r   <= y1_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_sample;
      s1_start_r  <= in_record_start;
    end
    if (s1_emit) begin
      out_filtered_r <= y_sel;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;

  a_kept_sat: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r != 2'd3)
    else $error("kept count past saturation");

  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    s1_emit && (kept_eff < dbq_pkg::PASS_CNT) |=> out_filtered_r == $past(s1_sample_r))
    else $error("pass-through sample altered");

  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && drop |=> out_valid_r == $past(out_valid_r && out_stall))
    else $error("dropped item produced a result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_filtered_r))
    else $error("stalled result lost");

endmodule

// ===== rtl/dbq_cfg_regs.sv =====
module dbq_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  dbq_pkg::cfg_idx_t  wr_index,
  input  dbq_pkg::coef_t     wr_data,
  output dbq_pkg::cfg_t      cfg
);

  dbq_pkg::cfg_t cfg_r;
  dbq_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        dbq_pkg::CFG_B0:  cfg_nxt.b0 = wr_data;
        dbq_pkg::CFG_B1:  cfg_nxt.b1 = wr_data;
        dbq_pkg::CFG_B2:  cfg_nxt.b2 = wr_data;
        dbq_pkg::CFG_A1:  cfg_nxt.a1 = wr_data;
        dbq_pkg::CFG_A2:  cfg_nxt.a2 = wr_data;
        dbq_pkg::CFG_DEC: cfg_nxt.decimate_enable = wr_data[0];
        default: ; // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.b0 <= dbq_pkg::B0_RST;
      cfg_r.b1 <= dbq_pkg::B1_RST;
      cfg_r.b2 <= dbq_pkg::B2_RST;
      cfg_r.a1 <= dbq_pkg::A1_RST;
      cfg_r.a2 <= dbq_pkg::A2_RST;
      cfg_r.decimate_enable <= dbq_pkg::DEC_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/dbq_mac.sv =====
module dbq_mac (
  input  dbq_pkg::cfg_t    cfg,
  input  dbq_pkg::taps_t   taps,
  output dbq_pkg::sample_t y
);

  localparam int ACC_W  = dbq_pkg::ACC_W;
  localparam int PROD_W = dbq_pkg::PROD_W;
  localparam int Q_W    = ACC_W - dbq_pkg::FRAC_W;

  logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [Q_W-1:0]    q;

  assign p_b0 = cfg.b0 * taps.x;
  assign p_b1 = cfg.b1 * taps.x1;
  assign p_b2 = cfg.b2 * taps.x2;
  assign p_a1 = cfg.a1 * taps.y1;
  assign p_a2 = cfg.a2 * taps.y2;

  assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
             - ACC_W'(p_a1) - ACC_W'(p_a2);

  // round half up, then floor by dropping the fraction
  assign acc_rnd = acc + (ACC_W'(1) <<< (dbq_pkg::FRAC_W - 1));
  assign q       = acc_rnd[ACC_W-1:dbq_pkg::FRAC_W];

  always_comb begin
    if (q > Q_W'(32'sd32767)) begin
      y = 16'sh7fff;
    end else if (q < -Q_W'(32'sd32768)) begin
      y = -16'sh8000;
    end else begin
      y = q[dbq_pkg::SAMPLE_W-1:0];
    end
  end

endmodule
